>>> rtl/fwow_pkg.sv
// Shared constants, types and helpers for the item/waiter matching FIFO.
package fwow_pkg;

    // Store sizes and data word width
    localparam int ITEM_DEPTH   = 16;
    localparam int WAITER_DEPTH = 16;
    localparam int DATA_WIDTH   = 32;

    // Fixed port widths
    localparam int PORT_VALUE_W = 32;
    localparam int ID_W         = 8;
    localparam int STATUS_W     = 2;
    localparam int ATTEMPT_W    = 32;

    // Derived address and count widths
    localparam int ITEM_AW   = $clog2(ITEM_DEPTH);
    localparam int ITEM_CW   = $clog2(ITEM_DEPTH + 1);
    localparam int WAITER_AW = $clog2(WAITER_DEPTH);
    localparam int WAITER_CW = $clog2(WAITER_DEPTH + 1);

    // Operation codes
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_SERVED      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ITEM_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_WAITER_FULL = 2'd2;

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic                push_item;
        logic                push_waiter;
        logic                pop_item;
        logic                pop_waiter;
        logic                count_attempt;
        logic                load_reject;
        logic                load_match;
        logic [STATUS_W-1:0] reject_status;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic item_full;
        logic item_empty;
        logic waiter_full;
        logic waiter_empty;
    } t_stat;

    // Fit a port word into the stored data width
    function automatic logic [DATA_WIDTH-1:0] to_data(input logic [PORT_VALUE_W-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[DATA_WIDTH-1:0];
    endfunction

    // Fit a stored data word onto the port width
    function automatic logic [PORT_VALUE_W-1:0] to_port(input logic [DATA_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[PORT_VALUE_W-1:0];
    endfunction

endpackage

>>> rtl/fwow_dp.sv
// Datapath: item and waiter stores, pointers, attempt counter and result register.
module fwow_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  fwow_pkg::t_cmd                       i_cmd,
    output fwow_pkg::t_stat                      o_stat,
    input  logic [fwow_pkg::PORT_VALUE_W-1:0]    i_item_value,
    input  logic [fwow_pkg::ID_W-1:0]            i_requester_id,
    output logic [fwow_pkg::STATUS_W-1:0]        o_status,
    output logic [fwow_pkg::ID_W-1:0]            o_served_id,
    output logic [fwow_pkg::PORT_VALUE_W-1:0]    o_served_value,
    output logic [fwow_pkg::ATTEMPT_W-1:0]       o_attempt_count
);
    import fwow_pkg::*;

    // Stores
    logic [DATA_WIDTH-1:0] item_mem   [ITEM_DEPTH];
    logic [ID_W-1:0]       waiter_mem [WAITER_DEPTH];

    // Pointers, counts and attempt counter
    logic [ITEM_AW-1:0]   r_item_head,   n_item_head;
    logic [ITEM_CW-1:0]   r_item_count,  n_item_count;
    logic [WAITER_AW-1:0] r_waiter_head, n_waiter_head;
    logic [WAITER_CW-1:0] r_waiter_count, n_waiter_count;
    logic [ATTEMPT_W-1:0] r_attempts;

    // Read data and the operand held from the matching transfer
    logic [DATA_WIDTH-1:0]   r_item_rd;
    logic [ID_W-1:0]         r_waiter_rd;
    logic [DATA_WIDTH-1:0]   r_hold_value;
    logic [ID_W-1:0]         r_hold_id;
    logic                    r_src_item;

    // Result register
    logic [STATUS_W-1:0]     r_status;
    logic [ID_W-1:0]         r_served_id;
    logic [PORT_VALUE_W-1:0] r_served_value;
    logic [ATTEMPT_W-1:0]    r_attempt_count;

    // Tail addresses: head plus count, wrapped once
    logic [ITEM_AW:0]     item_sum;
    logic [ITEM_AW-1:0]   item_tail;
    logic [WAITER_AW:0]   waiter_sum;
    logic [WAITER_AW-1:0] waiter_tail;

    always_comb begin
        item_sum = (ITEM_AW + 1)'(r_item_head) + (ITEM_AW + 1)'(r_item_count);
        if (item_sum >= (ITEM_AW + 1)'(ITEM_DEPTH)) begin
            item_sum = item_sum - (ITEM_AW + 1)'(ITEM_DEPTH);
        end
        item_tail = item_sum[ITEM_AW-1:0];

        waiter_sum = (WAITER_AW + 1)'(r_waiter_head) + (WAITER_AW + 1)'(r_waiter_count);
        if (waiter_sum >= (WAITER_AW + 1)'(WAITER_DEPTH)) begin
            waiter_sum = waiter_sum - (WAITER_AW + 1)'(WAITER_DEPTH);
        end
        waiter_tail = waiter_sum[WAITER_AW-1:0];
    end

    // Advance heads and counts
    always_comb begin
        n_item_head    = r_item_head;
        n_item_count   = r_item_count;
        n_waiter_head  = r_waiter_head;
        n_waiter_count = r_waiter_count;
        if (i_cmd.push_item) begin
            n_item_count = r_item_count + ITEM_CW'(1);
        end
        if (i_cmd.pop_item) begin
            n_item_count = r_item_count - ITEM_CW'(1);
            n_item_head  = (r_item_head == ITEM_AW'(ITEM_DEPTH - 1)) ?
                           '0 : r_item_head + ITEM_AW'(1);
        end
        if (i_cmd.push_waiter) begin
            n_waiter_count = r_waiter_count + WAITER_CW'(1);
        end
        if (i_cmd.pop_waiter) begin
            n_waiter_count = r_waiter_count - WAITER_CW'(1);
            n_waiter_head  = (r_waiter_head == WAITER_AW'(WAITER_DEPTH - 1)) ?
                             '0 : r_waiter_head + WAITER_AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_head    <= '0;
            r_item_count   <= '0;
            r_waiter_head  <= '0;
            r_waiter_count <= '0;
            r_attempts     <= '0;
        end else begin
            r_item_head    <= n_item_head;
            r_item_count   <= n_item_count;
            r_waiter_head  <= n_waiter_head;
            r_waiter_count <= n_waiter_count;
            if (i_cmd.count_attempt) begin
                r_attempts <= r_attempts + ATTEMPT_W'(1);
            end
        end
    end

    // Item store: write at tail, registered read at head
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_item) begin
            item_mem[item_tail] <= to_data(i_item_value);
        end
        if (i_cmd.pop_item) begin
            r_item_rd <= item_mem[r_item_head];
        end
    end

    // Waiter store: write at tail, registered read at head
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_waiter) begin
            waiter_mem[waiter_tail] <= i_requester_id;
        end
        if (i_cmd.pop_waiter) begin
            r_waiter_rd <= waiter_mem[r_waiter_head];
        end
    end

    // Hold the incoming half of a match while the store is read
    always_ff @(posedge i_clk) begin
        if (i_cmd.pop_item) begin
            r_hold_id  <= i_requester_id;
            r_src_item <= 1'b1;
        end
        if (i_cmd.pop_waiter) begin
            r_hold_value <= to_data(i_item_value);
            r_src_item   <= 1'b0;
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_reject) begin
            r_status        <= i_cmd.reject_status;
            r_served_id     <= '0;
            r_served_value  <= '0;
            r_attempt_count <= r_attempts;
        end else if (i_cmd.load_match) begin
            r_status        <= STATUS_SERVED;
            r_served_id     <= r_src_item ? r_hold_id : r_waiter_rd;
            r_served_value  <= to_port(r_src_item ? r_item_rd : r_hold_value);
            r_attempt_count <= r_attempts;
        end
    end

    assign o_stat.item_full    = (r_item_count == ITEM_CW'(ITEM_DEPTH));
    assign o_stat.item_empty   = (r_item_count == '0);
    assign o_stat.waiter_full  = (r_waiter_count == WAITER_CW'(WAITER_DEPTH));
    assign o_stat.waiter_empty = (r_waiter_count == '0);

    assign o_status        = r_status;
    assign o_served_id     = r_served_id;
    assign o_served_value  = r_served_value;
    assign o_attempt_count = r_attempt_count;

endmodule

>>> rtl/fwow_ctrl.sv
// Controller: accepts operations, steers pushes, pops and result loads.
module fwow_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_operation,
    output logic             o_valid,
    input  logic             i_ready,
    input  fwow_pkg::t_stat  i_stat,
    output fwow_pkg::t_cmd   o_cmd
);
    import fwow_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   accept;

    // Result register can take a new result this cycle
    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE) && out_free;
    assign accept   = i_valid && o_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_operation == OP_ENQUEUE) begin
                        if (!i_stat.item_full && !i_stat.waiter_empty) begin
                            n_state = S_READ;
                        end
                    end else begin
                        if (!i_stat.waiter_full && !i_stat.item_empty) begin
                            n_state = S_READ;
                        end
                    end
                end
            end
            S_READ: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_operation == OP_ENQUEUE) begin
                        if (i_stat.item_full) begin
                            o_cmd.load_reject   = 1'b1;
                            o_cmd.reject_status = STATUS_ITEM_FULL;
                        end else if (!i_stat.waiter_empty) begin
                            o_cmd.pop_waiter = 1'b1;
                        end else begin
                            o_cmd.push_item = 1'b1;
                        end
                    end else begin
                        if (i_stat.waiter_full) begin
                            o_cmd.load_reject   = 1'b1;
                            o_cmd.reject_status = STATUS_WAITER_FULL;
                        end else begin
                            o_cmd.count_attempt = 1'b1;
                            if (!i_stat.item_empty) begin
                                o_cmd.pop_item = 1'b1;
                            end else begin
                                o_cmd.push_waiter = 1'b1;
                            end
                        end
                    end
                end
            end
            S_READ: begin
                o_cmd.load_match = out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    // Track the result register
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.load_reject || o_cmd.load_match) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

>>> rtl/fifo_with_ordered_waiters.sv
// Top level: item FIFO matched in order against a FIFO of waiting requesters.
//
//  channel  direction  handshake           payload
//  in       input      i_valid / o_ready   i_operation, i_item_value, i_requester_id
//  out      output     o_valid / i_ready   o_status, o_served_id, o_served_value,
//                                          o_attempt_count
//
// A push with no match gives no result; a rejection is loaded on acceptance; a match
// passes through S_READ, as the oldest entry comes out of a store's registered read port.
// Every operation waits for the result register to be free or drained that cycle.
// Reset (synchronous, active low) empties both stores and clears the attempt count.
// A stalled result holds o_ready low for every operation until it is drained.
module fifo_with_ordered_waiters (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_operation,
    input  logic [fwow_pkg::PORT_VALUE_W-1:0]    i_item_value,
    input  logic [fwow_pkg::ID_W-1:0]            i_requester_id,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [fwow_pkg::STATUS_W-1:0]        o_status,
    output logic [fwow_pkg::ID_W-1:0]            o_served_id,
    output logic [fwow_pkg::PORT_VALUE_W-1:0]    o_served_value,
    output logic [fwow_pkg::ATTEMPT_W-1:0]       o_attempt_count
);
    import fwow_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    fwow_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    fwow_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_item_value    (i_item_value),
        .i_requester_id  (i_requester_id),
        .o_status        (o_status),
        .o_served_id     (o_served_id),
        .o_served_value  (o_served_value),
        .o_attempt_count (o_attempt_count)
    );

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the item/waiter matching FIFO.
`timescale 1ns / 100ps

module tb_top;
    import fwow_pkg::*;

    localparam int RANDOM_OPS   = 1400;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_TICKS = 10;

    // One result as seen on the output channel
    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [ID_W-1:0]         id;
        logic [PORT_VALUE_W-1:0] value;
        logic [ATTEMPT_W-1:0]    count;
    } t_match;

    // How a directed row gets its expectation
    typedef enum int {
        CHK_PREDICT,
        CHK_NONE,
        CHK_TYPED
    } t_check;

    typedef struct {
        logic                    op;
        logic [PORT_VALUE_W-1:0] value;
        logic [ID_W-1:0]         id;
        int                      reps;
        t_check                  chk;
        t_match                  want;
    } t_plan_row;

    localparam t_match NO_MATCH = '0;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic                    i_operation;
    logic [PORT_VALUE_W-1:0] i_item_value;
    logic [ID_W-1:0]         i_requester_id;
    logic                    o_valid;
    logic                    i_ready;
    logic [STATUS_W-1:0]     o_status;
    logic [ID_W-1:0]         o_served_id;
    logic [PORT_VALUE_W-1:0] o_served_value;
    logic [ATTEMPT_W-1:0]    o_attempt_count;

    // Shadow copy of both stores and the attempt counter
    logic [PORT_VALUE_W-1:0] model_items[$];
    logic [ID_W-1:0]         model_waiters[$];
    logic [ATTEMPT_W-1:0]    model_attempts;

    t_match    awaited_matches[$];
    t_plan_row plan[$];
    int        fail_count;
    int        idle_ticks;
    int        burst_left;
    bit        no_gap;

    fifo_with_ordered_waiters DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_operation     (i_operation),
        .i_item_value    (i_item_value),
        .i_requester_id  (i_requester_id),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_served_id     (o_served_id),
        .o_served_value  (o_served_value),
        .o_attempt_count (o_attempt_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Apply one operation to the shadow stores; return 1 when it yields a result
    function automatic bit next_match(input logic op, input logic [PORT_VALUE_W-1:0] val,
                                      input logic [ID_W-1:0] id, output t_match m);
        m = '0;
        if (op == OP_ENQUEUE) begin
            if (model_items.size() >= ITEM_DEPTH) begin
                m.status = STATUS_ITEM_FULL;
                m.count  = model_attempts;
                return 1'b1;
            end
            model_items.push_back(to_port(to_data(val)));
        end else begin
            if (model_waiters.size() >= WAITER_DEPTH) begin
                m.status = STATUS_WAITER_FULL;
                m.count  = model_attempts;
                return 1'b1;
            end
            model_waiters.push_back(id);
            model_attempts = model_attempts + ATTEMPT_W'(1);
        end
        // Pair the oldest waiter with the oldest item
        if (model_items.size() > 0 && model_waiters.size() > 0) begin
            m.status = STATUS_SERVED;
            m.id     = model_waiters.pop_front();
            m.value  = model_items.pop_front();
            m.count  = model_attempts;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Present one operation, hold it until the transfer, then log its expectation
    task automatic send_op(input logic op, input logic [PORT_VALUE_W-1:0] val,
                           input logic [ID_W-1:0] id, input t_check chk, input t_match want);
        int     gap;
        t_match m;
        bit     hit;
        if (burst_left == 0) begin
            gap        = no_gap ? 0 : $urandom_range(0, 24);
            burst_left = $urandom_range(1, 48);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid        <= 1'b1;
        i_operation    <= op;
        i_item_value   <= val;
        i_requester_id <= id;
        @(negedge i_clk);
        while (!o_ready) @(negedge i_clk);
        @(posedge i_clk);
        hit = next_match(op, val, id, m);
        case (chk)
            CHK_PREDICT: if (hit) awaited_matches.push_back(m);
            CHK_TYPED:   awaited_matches.push_back(want);
            default: ;
        endcase
    endtask

    // Stall the receiver in changing patterns
    initial begin
        int rx_mode;
        int rx_left;
        int rx_tick;
        rx_mode = 0;
        rx_left = 0;
        rx_tick = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(32, 256);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                0:       i_ready <= 1'b1;
                1:       i_ready <= 1'($urandom_range(0, 1));
                2:       i_ready <= ($urandom_range(0, 7) == 0);
                default: i_ready <= ((rx_tick % 12) < 7);
            endcase
        end
    end

    // Check each result transfer against the oldest expectation; watch for a hang
    always @(negedge i_clk) begin
        t_match got;
        t_match exp_m;
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_ticks = 0;
            else
                idle_ticks++;
            if (o_valid && i_ready) begin
                got = '{o_status, o_served_id, o_served_value, o_attempt_count};
                if (awaited_matches.size() == 0) begin
                    $display("%0t: unexpected result status %0d id %0h value %0h count %0d",
                             $realtime, got.status, got.id, got.value, got.count);
                    fail_count++;
                end else begin
                    exp_m = awaited_matches.pop_front();
                    if (got.status !== exp_m.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $realtime, exp_m.status, got.status);
                        fail_count++;
                    end
                    if (got.id !== exp_m.id) begin
                        $display("%0t: served_id expected %0h actual %0h",
                                 $realtime, exp_m.id, got.id);
                        fail_count++;
                    end
                    if (got.value !== exp_m.value) begin
                        $display("%0t: served_value expected %0h actual %0h",
                                 $realtime, exp_m.value, got.value);
                        fail_count++;
                    end
                    if (got.count !== exp_m.count) begin
                        $display("%0t: attempt_count expected %0d actual %0d",
                                 $realtime, exp_m.count, got.count);
                        fail_count++;
                    end
                end
            end
            if (idle_ticks >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $realtime, idle_ticks);
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain
    initial begin
        int                      k;
        int                      mode;
        int                      len;
        int                      random_left;
        bit                      first_phase;
        logic                    op;
        logic [PORT_VALUE_W-1:0] val;
        logic [ID_W-1:0]         id;

        fail_count     = 0;
        idle_ticks     = 0;
        burst_left     = 0;
        no_gap         = 1'b0;
        model_attempts = '0;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_operation    <= OP_ENQUEUE;
        i_item_value   <= '0;
        i_requester_id <= '0;

        // Fill the item store to overflow, drain it, then overflow the waiters
        plan.push_back('{OP_ENQUEUE, 32'hFFFF_FFFF, 8'h5A, 1,  CHK_NONE,    NO_MATCH});
        plan.push_back('{OP_ENQUEUE, 32'h0000_0000, 8'hA5, 1,  CHK_NONE,    NO_MATCH});
        plan.push_back('{OP_ENQUEUE, 32'h1234_5678, 8'h00, 13, CHK_PREDICT, NO_MATCH});
        plan.push_back('{OP_ENQUEUE, 32'h8000_0000, 8'hFF, 1,  CHK_PREDICT, NO_MATCH});
        plan.push_back('{OP_ENQUEUE, 32'hDEAD_BEEF, 8'h11, 1,  CHK_TYPED,
                         '{STATUS_ITEM_FULL, 8'h00, 32'h0, 32'd0}});
        plan.push_back('{OP_DEQUEUE, 32'hFFFF_FFFF, 8'hFF, 1,  CHK_TYPED,
                         '{STATUS_SERVED, 8'hFF, 32'hFFFF_FFFF, 32'd1}});
        plan.push_back('{OP_DEQUEUE, 32'h0000_0000, 8'h00, 1,  CHK_TYPED,
                         '{STATUS_SERVED, 8'h00, 32'h0000_0000, 32'd2}});
        plan.push_back('{OP_DEQUEUE, 32'h0F0F_0F0F, 8'h80, 14, CHK_PREDICT, NO_MATCH});
        plan.push_back('{OP_DEQUEUE, 32'hF0F0_F0F0, 8'h01, 16, CHK_PREDICT, NO_MATCH});
        plan.push_back('{OP_DEQUEUE, 32'hFFFF_FFFF, 8'h7F, 1,  CHK_TYPED,
                         '{STATUS_WAITER_FULL, 8'h00, 32'h0, 32'd32}});
        plan.push_back('{OP_ENQUEUE, 32'h5555_5555, 8'hFF, 1,  CHK_TYPED,
                         '{STATUS_SERVED, 8'h01, 32'h5555_5555, 32'd32}});
        plan.push_back('{OP_ENQUEUE, 32'hAAAA_AAAA, 8'h00, 1,  CHK_PREDICT, NO_MATCH});

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (plan[r]) begin
            for (k = 0; k < plan[r].reps; k++) begin
                send_op(plan[r].op, plan[r].value + PORT_VALUE_W'(k),
                        plan[r].id + ID_W'(k), plan[r].chk, plan[r].want);
            end
        end

        // Random phases, each with its own operation mix
        random_left = RANDOM_OPS;
        first_phase = 1'b1;
        while (random_left > 0) begin
            mode   = $urandom_range(0, 4);
            len    = $urandom_range(10, 80);
            no_gap = ($urandom_range(0, 3) == 0);
            for (k = 0; k < len && random_left > 0; k++) begin
                case (mode)
                    0:       op = 1'($urandom_range(0, 1));
                    1:       op = ($urandom_range(0, 4) == 0) ? OP_DEQUEUE : OP_ENQUEUE;
                    2:       op = ($urandom_range(0, 4) == 0) ? OP_ENQUEUE : OP_DEQUEUE;
                    3:       op = OP_ENQUEUE;
                    default: op = OP_DEQUEUE;
                endcase
                case ($urandom_range(0, 5))
                    0:       val = '0;
                    1:       val = '1;
                    2:       val = PORT_VALUE_W'(1) << $urandom_range(0, PORT_VALUE_W - 1);
                    default: val = $urandom;
                endcase
                id = ID_W'($urandom_range(0, 255));
                send_op(op, val, id, CHK_PREDICT, NO_MATCH);
                random_left--;
            end
            // Hold off the sender until every pending result is out
            if (first_phase || $urandom_range(0, 3) == 0) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (awaited_matches.size() != 0) @(posedge i_clk);
                burst_left = 0;
            end
            first_phase = 1'b0;
        end

        // Drain and let the pipeline settle
        i_valid <= 1'b0;
        while (awaited_matches.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
